// ----- design/rconv_pkg.sv -----
package rconv_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int STORE_DEPTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int BASE_W    = 5;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W     = $clog2(STORE_DEPTH);
   localparam int BIT_CNT_W = $clog2(VALUE_BITS);
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [BASE_W-1:0] BASE_MIN          = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX          = 5'd16;
   localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BASE = 1'b1;

   typedef logic [BASE_W-1:0] base_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  bad;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_READ,
      BK_SHOW,
      BK_ERROR
   } back_state_type;

   // Out-of-range bases saturate into 2..16.
   function automatic base_type clamp_base(base_type b);
      base_type r;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

// ----- design/rconv_front.sv -----
module rconv_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rconv_pkg::CHAR_W-1:0]   req_digit_char,
   input  logic                           req_last_char,
   input  rconv_pkg::base_type            source_base,
   output logic                           push_valid,
   input  logic                           push_ready,
   output rconv_pkg::job_type             push_job
);
   import rconv_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF   = 8'h46;
   localparam logic [CHAR_W-1:0] TEN       = 8'd10;
   localparam logic [BASE_W-1:0] NOT_DIGIT = 5'd16;
   localparam int                PROD_W    = VALUE_BITS + BASE_W;

   // Digit value of a hex character, or NOT_DIGIT.
   function automatic logic [BASE_W-1:0] char_value(logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] r;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = BASE_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         r = BASE_W'(c - CHAR_LA + TEN);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         r = BASE_W'(c - CHAR_UA + TEN);
      end else begin
         r = NOT_DIGIT;
      end
      return r;
   endfunction

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  inv_ff, inv_in;
   base_type              sb;
   logic [BASE_W-1:0]     dval;
   logic                  digit_ok;
   logic [PROD_W-1:0]     prod;
   logic [VALUE_BITS-1:0] sum;
   logic                  accept;

   assign req_ready = push_ready;
   assign accept    = req_valid & req_ready;

   always_comb begin
      sb       = clamp_base(source_base);
      dval     = char_value(req_digit_char);
      digit_ok = (dval < sb);
      prod     = PROD_W'(acc_ff) * PROD_W'(sb);
      sum      = VALUE_BITS'(prod) + VALUE_BITS'(dval);

      push_valid     = accept & req_last_char;
      push_job.value = digit_ok ? sum : acc_ff;
      push_job.bad   = inv_ff | ~digit_ok;

      acc_in = acc_ff;
      inv_in = inv_ff;
      if (accept) begin
         if (req_last_char) begin
            acc_in = '0;
            inv_in = 1'b0;
         end else begin
            if (digit_ok) begin
               acc_in = sum;
            end
            inv_in = inv_ff | ~digit_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         inv_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         inv_ff <= inv_in;
      end
   end

endmodule

// ----- design/rconv_queue.sv -----
module rconv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rconv_pkg::job_type push_job,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rconv_pkg::job_type pop_job
);
   import rconv_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff < QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/rconv_back.sv -----
module rconv_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rconv_pkg::base_type          target_base,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  rconv_pkg::job_type           pop_job,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rconv_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                         rsp_last_digit,
   output logic                         rsp_bad_input
);
   import rconv_pkg::*;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_UA   = 8'h41;
   localparam logic [DIGIT_W-1:0] TEN       = 4'd10;

   function automatic logic [CHAR_W-1:0] to_ascii(logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < TEN) begin
         r = CHAR_ZERO + CHAR_W'(d);
      end else begin
         r = CHAR_UA + CHAR_W'(d - TEN);
      end
      return r;
   endfunction

   back_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0]  work_ff, work_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [DIGIT_W-1:0]     rd_digit_ff;
   logic [DIGIT_W-1:0]     digit_store [STORE_DEPTH];

   base_type               tb;
   logic [DIGIT_W:0]       shifted;
   logic                   ge;
   logic [DIGIT_W:0]       diff;
   logic [VALUE_BITS-1:0]  work_step;
   logic [DIGIT_W-1:0]     rem_step;
   logic                   store_we;

   // One restoring-division bit per cycle.
   always_comb begin
      tb        = clamp_base(target_base);
      shifted   = {rem_ff, work_ff[VALUE_BITS-1]};
      ge        = (shifted >= tb);
      diff      = shifted - tb;
      rem_step  = ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
      work_step = {work_ff[VALUE_BITS-2:0], ge};
   end

   always_comb begin
      state_in       = state_ff;
      work_in        = work_ff;
      rem_in         = rem_ff;
      bit_cnt_in     = bit_cnt_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      store_we       = 1'b0;
      pop_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_out_char   = '0;
      rsp_last_digit = 1'b0;
      rsp_bad_input  = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               work_in    = pop_job.value;
               rem_in     = '0;
               bit_cnt_in = '0;
               count_in   = '0;
               state_in   = pop_job.bad ? BK_ERROR : BK_DIV;
            end
         end
         BK_DIV: begin
            work_in    = work_step;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1)) begin
               store_we   = 1'b1;
               count_in   = count_ff + 1'b1;
               rem_in     = '0;
               bit_cnt_in = '0;
               if (work_step == '0 || count_in == CNT_W'(STORE_DEPTH)) begin
                  idx_in   = count_ff[IDX_W-1:0];
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in = BK_SHOW;
         end
         BK_SHOW: begin
            rsp_valid      = 1'b1;
            rsp_out_char   = to_ascii(rd_digit_ff);
            rsp_last_digit = (idx_ff == '0);
            if (rsp_ready) begin
               if (idx_ff == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_ERROR: begin
            rsp_valid      = 1'b1;
            rsp_last_digit = 1'b1;
            rsp_bad_input  = 1'b1;
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[count_ff[IDX_W-1:0]] <= rem_step;
      end
      rd_digit_ff <= digit_store[idx_ff];
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/radix_converter.sv -----
// Radix converter: takes the ASCII digits of a non-negative number in source_base
// (2..16, upper or lower case letters), most significant first, one transaction per
// character with req_last_char on the final one, and answers with the number in
// target_base as uppercase ASCII digits, most significant first, rsp_last_digit on
// the final one. A character that is not a digit below the source base turns the
// whole number into a single transaction with rsp_bad_input set and rsp_out_char 0.
// Zero comes out as a single '0'. The value wraps modulo 2^32. Bases outside 2..16
// saturate. Characters are taken one per cycle while the queue has room; a finished
// number waits in a two-entry queue while the back end converts the previous one.
// Conversion divides by the target base one quotient bit per cycle; each output
// digit takes a full division pass, and once all are stored, each is read back
// from the digit store and then output. Change the CSRs only while the block is
// idle.
module radix_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rconv_pkg::CHAR_W-1:0]      req_digit_char,
   input  logic                              req_last_char,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rconv_pkg::CHAR_W-1:0]      rsp_out_char,
   output logic                              rsp_last_digit,
   output logic                              rsp_bad_input,
   input  logic                              csr_write_en,
   input  logic [rconv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rconv_pkg::BASE_W-1:0]      csr_write_data
);
   import rconv_pkg::*;

   base_type source_base_ff;
   base_type target_base_ff;
   logic     push_valid, push_ready;
   job_type  push_job;
   logic     pop_valid, pop_ready;
   job_type  pop_job;

   // CSR writes land immediately; unknown indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_base_ff <= SOURCE_BASE_RESET;
         target_base_ff <= TARGET_BASE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SOURCE_BASE: source_base_ff <= csr_write_data;
            CSR_TARGET_BASE: target_base_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Front end: validate and accumulate characters, hand off finished numbers.
   rconv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_digit_char (req_digit_char),
      .req_last_char  (req_last_char),
      .source_base    (source_base_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   // Hold finished numbers so the front end keeps taking characters.
   rconv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back end: divide out target digits, then stream them most significant first.
   rconv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .target_base    (target_base_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_input  (rsp_bad_input)
   );

endmodule

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rconv_pkg::*;

   // ASCII anchors for digit parsing and formatting
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
   localparam logic [4:0]        NOT_A_DIGIT = 5'd16;

   localparam int PHASE_ITEMS  = 60;   // minimum characters queued per random phase
   localparam int RANDOM_PHASES = 8;
   localparam int DRAIN_CYCLES = 64;   // settle time after the last digit
   localparam int HOLD_AT      = 50;   // start the long receiver hold here
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 6000; // idle limit, well above the worst base-2 number

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_item_t;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              last_digit;
      logic              bad_input;
   } out_digit_t;

   // DUT ports; every input starts at a known value
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_digit_char = '0;
   logic                 req_last_char = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAR_W-1:0]    rsp_out_char;
   logic                 rsp_last_digit;
   logic                 rsp_bad_input;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SOURCE_BASE;
   logic [BASE_W-1:0]    csr_write_data = '0;

   // stimulus and scoreboard
   char_item_t pending_chars[$];
   out_digit_t expected_digits[$];
   int         queued_count = 0;
   int         taken_count = 0;
   int         error_count = 0;
   int         idle_cycles = 0;
   logic       steady = 1'b0;      // no gaps on either side while set
   logic       req_taken = 1'b0;
   logic       rsp_taken = 1'b0;
   int         req_gap = 0;
   int         rsp_gap = 0;
   int         hold_left = 0;
   logic       long_hold_done = 1'b0;

   // predictor state, mirrors the block's registers and accumulator
   logic [BASE_W-1:0]     src_radix;
   logic [BASE_W-1:0]     dst_radix;
   logic [VALUE_BITS-1:0] acc_value;
   logic                  bad_seen;

   logic [4:0] gen_radix;          // clamped source base used by the generator

   radix_converter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_digit_char (req_digit_char),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_input  (rsp_bad_input),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Saturate a register value into the legal 2..16 range.
   function automatic logic [4:0] clamp_radix(input logic [BASE_W-1:0] b);
      if (b < 5'd2) return 5'd2;
      if (b > 5'd16) return 5'd16;
      return b;
   endfunction

   // Digit value of an ASCII hex character, NOT_A_DIGIT otherwise.
   function automatic logic [4:0] digit_value(input logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return 5'(c - CH_LOW_A + 8'd10);
      if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
      return NOT_A_DIGIT;
   endfunction

   // ASCII for a digit value; letters in either case on request.
   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] d, input logic lower);
      if (d < 4'd10) return CH_ZERO + 8'(d);
      return (lower ? CH_LOW_A : CH_UP_A) + 8'(d) - 8'd10;
   endfunction

   // Gap before the next transaction: mostly none, some short, a few long; none when no_idle is set.
   function automatic int pick_gap(input logic no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Fold one accepted character into the accumulator; on the last one,
   // convert and queue the digits the block must emit.
   task automatic convert_char(input logic [CHAR_W-1:0] ch, input logic last);
      logic [4:0]            sb;
      logic [4:0]            tb;
      logic [4:0]            dv;
      logic [VALUE_BITS-1:0] v;
      logic [3:0]            digs[STORE_DEPTH];
      int                    n;
      out_digit_t            od;
      sb = clamp_radix(src_radix);
      dv = digit_value(ch);
      if (dv < sb) acc_value = acc_value * sb + dv;
      else bad_seen = 1'b1;
      if (!last) return;
      if (bad_seen) begin
         od.out_char   = '0;
         od.last_digit = 1'b1;
         od.bad_input  = 1'b1;
         expected_digits.push_back(od);
      end else begin
         tb = clamp_radix(dst_radix);
         v  = acc_value;
         n  = 0;
         // least significant digit first; zero still yields one digit
         do begin
            digs[n] = 4'(v % tb);
            n++;
            v = v / tb;
         end while (v != 0 && n < STORE_DEPTH);
         for (int k = n - 1; k >= 0; k--) begin
            od.out_char   = digit_ascii(digs[k], 1'b0);
            od.last_digit = (k == 0);
            od.bad_input  = 1'b0;
            expected_digits.push_back(od);
         end
      end
      acc_value = '0;
      bad_seen  = 1'b0;
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
      char_item_t it;
      it.ch   = ch;
      it.last = last;
      pending_chars.push_back(it);
      queued_count++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   // One number in the generator's base: random digits and letter case,
   // sometimes all top digits, sometimes one character replaced by a random byte.
   task automatic queue_number(input int len);
      logic             corrupt;
      logic             maxed;
      int               bad_pos;
      logic [3:0]       d;
      logic [CHAR_W-1:0] ch;
      corrupt = ($urandom_range(0, 99) < 15);
      maxed   = ($urandom_range(0, 99) < 5);
      bad_pos = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
         d  = maxed ? 4'(gen_radix - 1) : 4'($urandom_range(0, gen_radix - 1));
         ch = digit_ascii(d, 1'($urandom_range(0, 1)));
         if (corrupt && k == bad_pos) ch = 8'($urandom_range(0, 255));
         push_char(ch, k == len - 1);
      end
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 92) return $urandom_range(7, 12);
      return $urandom_range(13, 34);   // the longest can wrap the accumulator
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] dst);
      write_csr(CSR_SOURCE_BASE, src);
      write_csr(CSR_TARGET_BASE, dst);
      gen_radix = clamp_radix(src);
   endtask

   // Wait for every queued character to be taken and every digit to come
   // back, then give the back end time to settle.
   task automatic drain();
      do @(negedge clock);
      while (taken_count != queued_count || expected_digits.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Request driver: advance to the next character only after the current
   // transaction is taken; hold valid and payload until then.
   always @(negedge clock) begin
      char_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_chars.size() != 0) begin
            it = pending_chars.pop_front();
            req_valid      <= 1'b1;
            req_digit_char <= it.ch;
            req_last_char  <= it.last;
            req_gap        <= pick_gap(steady);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready: random gaps, plus one long hold once the random
   // traffic is under way so the block backs up and drops req_ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && taken_count >= HOLD_AT) begin
         rsp_ready      <= 1'b0;
         hold_left      <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_taken) rsp_gap <= pick_gap(steady);
      end
   end

   // Monitor: sample both channels and the CSR port at the rising edge,
   // check results against the oldest expectation, run the predictor,
   // and watch for a stalled run.
   always @(posedge clock) begin
      out_digit_t od;
      if (reset) begin
         src_radix   = SOURCE_BASE_RESET;
         dst_radix   = TARGET_BASE_RESET;
         acc_value   = '0;
         bad_seen    = 1'b0;
         idle_cycles = 0;
         req_taken  <= 1'b0;
         rsp_taken  <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (csr_write_en) begin
            if (csr_index == CSR_SOURCE_BASE) src_radix = csr_write_data;
            else dst_radix = csr_write_data;
         end
         // check first, so a stray result never consumes a fresh expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected result char %h last %b bad %b", $time,
                        rsp_out_char, rsp_last_digit, rsp_bad_input);
               error_count++;
            end else begin
               od = expected_digits.pop_front();
               if (rsp_out_char !== od.out_char) begin
                  $display("%0t: out_char expected %h actual %h", $time,
                           od.out_char, rsp_out_char);
                  error_count++;
               end
               if (rsp_last_digit !== od.last_digit) begin
                  $display("%0t: last_digit expected %b actual %b", $time,
                           od.last_digit, rsp_last_digit);
                  error_count++;
               end
               if (rsp_bad_input !== od.bad_input) begin
                  $display("%0t: bad_input expected %b actual %b", $time,
                           od.bad_input, rsp_bad_input);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            convert_char(req_digit_char, req_last_char);
            taken_count++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
               $display("tb_top failed");
               $finish;
            end
         end
      end
   end

   // Sequence: reset, directed numbers under a few base settings, then
   // random phases with fresh bases each time.
   initial begin
      logic [BASE_W-1:0] src_pick[5];
      logic [BASE_W-1:0] dst_pick[5];
      int                filled;
      int                len;
      src_pick = '{5'd2, 5'd16, 5'd10, 5'd0, 5'd31};
      dst_pick = '{5'd16, 5'd2, 5'd10, 5'd31, 5'd1};
      gen_radix = clamp_radix(SOURCE_BASE_RESET);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset bases, 10 to 16: zero, and a char just above '9'
      push_text("0");
      push_text("1:");
      drain();

      // hex to binary: mixed case, widest output, letters past 'F' and 'f'
      set_bases(5'd16, 5'd2);
      push_text("fF");
      push_text("FFFFFFFF");
      push_text("G");
      push_text("g1");
      drain();

      // register values below 2 and above 16 saturate
      set_bases(5'd0, 5'd31);
      push_text("12");
      push_text("10");
      drain();

      set_bases(5'd31, 5'd1);
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(CH_ZERO + 8'd1, 1'b1);
      push_text("7");
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 5) set_bases(src_pick[p], dst_pick[p]);
         else set_bases(BASE_W'($urandom_range(0, 31)), BASE_W'($urandom_range(0, 31)));
         steady <= (p == 3);
         filled = 0;
         while (filled < PHASE_ITEMS) begin
            len = pick_len();
            queue_number(len);
            filled += len;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
